FILE: hw/rtl/mptf_pkg.sv
// package for the markdown plain text filter
// item types, filter descriptor and character codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mptf_pkg;

  localparam int unsigned LIMIT_BITS  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned BEAT_BITS   = 3;

  localparam logic [7:0] CHAR_TICK  = 8'h60;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_LBRK  = 8'h5B;
  localparam logic [7:0] CHAR_RBRK  = 8'h5D;
  localparam logic [7:0] CHAR_LPAR  = 8'h28;
  localparam logic [7:0] CHAR_RPAR  = 8'h29;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_present;
    logic       out_last;
  } out_item_t;

  // work for the back end: ticks, then byte, then dots or a bare marker
  typedef struct packed {
    logic [1:0] ticks;
    logic       byte_vld;
    logic [7:0] data;
    logic       dots;
    logic       bare;
    logic       last;
  } op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mptf_front.sv
// front end of the filter: accepts bytes, tracks text state, builds descriptors
// depends on mptf_pkg
`timescale 1ns / 1ps
`default_nettype none

module mptf_front #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  input  wire [mptf_pkg::LIMIT_BITS-1:0]  cfg_data_i,
  input  wire                             in_fire_i,
  input  wire mptf_pkg::in_item_t         item_i,
  output mptf_pkg::op_t                   op_o,
  output logic                            push_o
);
  import mptf_pkg::*;

  localparam int unsigned SumBits = COUNT_BITS + 2;
  localparam int unsigned CmpBits = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  function automatic logic is_markup(input logic [7:0] b);
    return (b == CHAR_HASH) || (b == CHAR_STAR) || (b == CHAR_UNDER) || (b == CHAR_TICK) ||
           (b == CHAR_GT) || (b == CHAR_LBRK) || (b == CHAR_RBRK) || (b == CHAR_LPAR) ||
           (b == CHAR_RPAR) || (b == CHAR_BANG);
  endfunction

  logic [LIMIT_BITS-1:0] limit_q;
  logic                  code_q, code_d;
  logic                  lws_q, lws_d;
  logic [1:0]            pend_q, pend_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  halt_q, halt_d;

  logic                  proc;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic [1:0]            ticks_pre;
  logic [1:0]            ticks_end;
  logic [1:0]            ticks_tot;
  logic                  lws_mid;
  logic                  check_halt;
  logic [SumBits-1:0]    sum;
  logic [COUNT_BITS-1:0] count_fin;
  logic                  lim_hit;
  logic                  dots;

  always_comb begin
    code_d     = code_q;
    lws_d      = lws_q;
    pend_d     = pend_q;
    halt_d     = halt_q;
    emit       = 1'b0;
    emit_byte  = item_i.text_byte;
    ticks_pre  = 2'd0;
    check_halt = 1'b0;
    lws_mid    = (pend_q != 2'd0) ? 1'b0 : lws_q;
    proc       = item_i.byte_present && !halt_q;

    if (proc) begin
      if (item_i.text_byte == CHAR_TICK) begin
        if (pend_q == 2'd2) begin
          code_d = !code_q;
          pend_d = 2'd0;
        end else begin
          pend_d = pend_q + 2'd1;
        end
      end else if (code_q) begin
        ticks_pre = pend_q;
        pend_d    = 2'd0;
        lws_d     = lws_mid;
        if (item_i.text_byte == CHAR_NL) begin
          if (!lws_mid) begin
            emit      = 1'b1;
            emit_byte = CHAR_SPACE;
            lws_d     = 1'b1;
          end
        end else if (!is_ws(item_i.text_byte)) begin
          emit  = 1'b1;
          lws_d = 1'b0;
        end
      end else begin
        pend_d = 2'd0;
        if (!is_markup(item_i.text_byte)) begin
          check_halt = 1'b1;
          if (is_ws(item_i.text_byte)) begin
            if (!lws_q) begin
              emit      = 1'b1;
              emit_byte = CHAR_SPACE;
              lws_d     = 1'b1;
            end
          end else begin
            emit  = 1'b1;
            lws_d = 1'b0;
          end
        end
      end
    end

    // halt is only ever set outside code, so the old flag serves here
    ticks_end = (item_i.end_of_text && code_d && !halt_q) ? pend_d : 2'd0;
    ticks_tot = ticks_pre | ticks_end;

    sum = SumBits'(count_q) + SumBits'(ticks_tot) + SumBits'(emit);
    count_fin = (sum > SumBits'(CountMax)) ? CountMax : sum[COUNT_BITS-1:0];
    lim_hit = (limit_q != '0) && (CmpBits'(count_fin) >= CmpBits'(limit_q));

    if (check_halt && lim_hit) begin
      halt_d = 1'b1;
    end
    count_d = count_fin;
    dots    = item_i.end_of_text && lim_hit;

    op_o.ticks    = ticks_tot;
    op_o.byte_vld = emit;
    op_o.data     = emit_byte;
    op_o.dots     = dots;
    op_o.bare     = item_i.end_of_text && (ticks_tot == 2'd0) && !emit && !dots;
    op_o.last     = item_i.end_of_text;
    push_o        = in_fire_i && ((ticks_tot != 2'd0) || emit || item_i.end_of_text);

    if (item_i.end_of_text) begin
      code_d  = 1'b0;
      lws_d   = 1'b0;
      pend_d  = 2'd0;
      count_d = '0;
      halt_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      code_q  <= 1'b0;
      lws_q   <= 1'b0;
      pend_q  <= 2'd0;
      count_q <= '0;
      halt_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (in_fire_i) begin
        code_q  <= code_d;
        lws_q   <= lws_d;
        pend_q  <= pend_d;
        count_q <= count_d;
        halt_q  <= halt_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mptf_queue.sv
// short descriptor queue between front and back end
// depends on mptf_pkg
`timescale 1ns / 1ps
`default_nettype none

module mptf_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire mptf_pkg::op_t  op_i,
  input  wire                 pop_i,
  output mptf_pkg::op_t       head_o,
  output logic                empty_o,
  output logic                full_o
);
  import mptf_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QUEUE_DEPTH - 1);

  op_t               mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntBits'(QUEUE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mptf_back.sv
// back end of the filter: expands each descriptor into output beats
// depends on mptf_pkg; holds the output register
`timescale 1ns / 1ps
`default_nettype none

module mptf_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire mptf_pkg::op_t   head_i,
  input  wire                  empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output mptf_pkg::out_item_t  out_item_o
);
  import mptf_pkg::*;

  logic [BEAT_BITS-1:0] idx_q, idx_d;
  logic [BEAT_BITS-1:0] total;
  logic [BEAT_BITS-1:0] ticks_w;
  logic [BEAT_BITS-1:0] pre_w;
  logic                 adv;
  logic                 final_beat;
  logic                 out_vld_q;
  out_item_t            out_q, beat;

  always_comb begin
    ticks_w    = BEAT_BITS'(head_i.ticks);
    pre_w      = ticks_w + BEAT_BITS'(head_i.byte_vld);
    total      = pre_w + (head_i.dots ? BEAT_BITS'(3) : '0) + BEAT_BITS'(head_i.bare);
    adv        = !empty_i && (!out_vld_q || out_ready_i);
    final_beat = (idx_q == total - BEAT_BITS'(1));
    pop_o      = adv && final_beat;
    idx_d      = idx_q;
    if (adv) begin
      idx_d = final_beat ? '0 : idx_q + BEAT_BITS'(1);
    end

    beat.out_present = 1'b1;
    beat.out_last    = head_i.last && final_beat;
    if (idx_q < ticks_w) begin
      beat.out_byte = CHAR_TICK;
    end else if (idx_q < pre_w) begin
      beat.out_byte = head_i.data;
    end else if (head_i.dots) begin
      beat.out_byte = CHAR_DOT;
    end else begin
      beat.out_byte    = 8'h00;
      beat.out_present = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/markdown_plain_text_filter_unit.sv
// top level of the markdown plain text filter
// depends on mptf_pkg, mptf_front, mptf_queue, mptf_back
//
//   port group  direction  beat contents
//   in_*        sink       text_byte, byte_present, end_of_text
//   out_*       source     out_byte, out_present, out_last
//   cfg_*       sink       length_limit (16 bits)
//
// one input beat per cycle while the descriptor queue has room
// an item yields zero to six output beats; the back end sends one a cycle
// while the receiver is ready; multi-beat items (held backticks, trailing dots)
// hold the queue head, so the input stalls when the queue is full
// reset clears text state, length limit and queue; cfg is always ready
`timescale 1ns / 1ps
`default_nettype none

module markdown_plain_text_filter_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire mptf_pkg::in_item_t        in_item_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output mptf_pkg::out_item_t            out_item_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [mptf_pkg::LIMIT_BITS-1:0] cfg_data_i
);
  import mptf_pkg::*;

  op_t  front_op, head_op;
  logic push, pop, q_empty, q_full;
  logic in_fire;

  assign in_ready_o  = !q_full;
  assign in_fire     = in_valid_i && !q_full;
  assign cfg_ready_o = 1'b1;

  mptf_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .item_i      (in_item_i),
    .op_o        (front_op),
    .push_o      (push)
  );

  mptf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .head_o  (head_op),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mptf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_op),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mptf_checker.sv
// port level checks for the markdown plain text filter, bound to the top level
// depends on mptf_pkg and markdown_plain_text_filter_unit
`timescale 1ns / 1ps
`default_nettype none

module mptf_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       out_valid_o,
  input wire                       out_ready_i,
  input wire mptf_pkg::out_item_t  out_item_o,
  input wire                       cfg_ready_o
);
  import mptf_pkg::*;

  // a bare end marker only ever closes a text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.out_present |-> out_item_o.out_last)
    else $error("bare marker without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.out_present |-> out_item_o.out_byte == 8'h00)
    else $error("bare marker carries data");

  // whitespace leaves only as a plain space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.out_byte == 8'h09 || out_item_o.out_byte == 8'h0A ||
                      out_item_o.out_byte == 8'h0B || out_item_o.out_byte == 8'h0C ||
                      out_item_o.out_byte == 8'h0D))
    else $error("raw whitespace on output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg not ready");

endmodule

bind markdown_plain_text_filter_unit mptf_checker u_mptf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// testbench for markdown_plain_text_filter_unit: directed and random texts checked beat by beat
// against a built-in filter predictor; depends on mptf_pkg and the filter rtl

module tb_top;
  import mptf_pkg::*;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_item   = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LIMIT_BITS-1:0] cfg_data  = '0;

  // predictor state
  logic        code_on;
  logic        last_space;
  logic        halted_st;
  int unsigned tick_cnt;
  logic [15:0] out_len;
  logic [15:0] limit_val;

  out_item_t   expected_q[$];
  logic [7:0]  text_bytes[$];

  int send_idle_pct = 7;
  int recv_idle_pct = 61;
  int fail_count    = 0;
  int items_sent    = 0;
  int texts_sent    = 0;
  int beats_checked = 0;
  int stall_cycles  = 0;

  markdown_plain_text_filter_unit #(
    .COUNT_BITS(16)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic in_item_t mk(logic [7:0] b, logic p, logic e);
    in_item_t it;
    it.text_byte    = b;
    it.byte_present = p;
    it.end_of_text  = e;
    return it;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic logic is_markup(logic [7:0] b);
    case (b)
      CHAR_HASH, CHAR_STAR, CHAR_UNDER, CHAR_TICK, CHAR_GT,
      CHAR_LBRK, CHAR_RBRK, CHAR_LPAR, CHAR_RPAR, CHAR_BANG: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic limit_hit();
    return (limit_val != 16'd0) && (out_len >= limit_val);
  endfunction

  function automatic void clear_text();
    code_on    = 1'b0;
    last_space = 1'b0;
    halted_st  = 1'b0;
    tick_cnt   = 0;
    out_len    = 16'd0;
  endfunction

  function automatic void push_beat(logic [7:0] b, logic p, logic counted);
    out_item_t o;
    o.out_byte    = b;
    o.out_present = p;
    o.out_last    = 1'b0;
    expected_q.push_back(o);
    if (counted && out_len != COUNT_MAX) out_len++;
  endfunction

  function automatic void flush_held_ticks();
    while (tick_cnt > 0) begin
      push_beat(CHAR_TICK, 1'b1, 1'b1);
      tick_cnt--;
      last_space = 1'b0;
    end
  endfunction

  // expected output beats of one input item
  function automatic void filter_predict(in_item_t it);
    int        start_len;
    out_item_t tail;
    start_len = expected_q.size();
    if (it.byte_present && !halted_st) begin
      if (it.text_byte == CHAR_TICK) begin
        tick_cnt++;
        if (tick_cnt >= 3) begin
          code_on  = ~code_on;
          tick_cnt = 0;
        end
      end else if (code_on) begin
        flush_held_ticks();
        if (it.text_byte == CHAR_NL) begin
          if (!last_space) begin
            push_beat(CHAR_SPACE, 1'b1, 1'b1);
            last_space = 1'b1;
          end
        end else if (!is_space(it.text_byte)) begin
          push_beat(it.text_byte, 1'b1, 1'b1);
          last_space = 1'b0;
        end
      end else begin
        tick_cnt = 0;
        if (!is_markup(it.text_byte)) begin
          if (is_space(it.text_byte)) begin
            if (!last_space) begin
              push_beat(CHAR_SPACE, 1'b1, 1'b1);
              last_space = 1'b1;
            end
          end else begin
            push_beat(it.text_byte, 1'b1, 1'b1);
            last_space = 1'b0;
          end
          if (limit_hit()) halted_st = 1'b1;
        end
      end
    end
    if (it.end_of_text) begin
      if (code_on && !halted_st) flush_held_ticks();
      tick_cnt = 0;
      if (limit_hit()) begin
        repeat (3) push_beat(CHAR_DOT, 1'b1, 1'b0);
      end
      if (expected_q.size() == start_len) push_beat(8'h00, 1'b0, 1'b0);
      tail = expected_q.pop_back();
      tail.out_last = 1'b1;
      expected_q.push_back(tail);
      clear_text();
    end
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_item(in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    filter_predict(it);
    items_sent++;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // sends text_bytes, end flag on the last byte or on a bare end marker
  task automatic send_text(logic bare_end);
    foreach (text_bytes[i]) begin
      send_item(mk(text_bytes[i], 1'b1, !bare_end && (i == text_bytes.size() - 1)));
    end
    if (bare_end) send_item(mk(8'h00, 1'b0, 1'b1));
    texts_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] value);
    drain_and_settle();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_val = value;
  endtask

  task automatic test_markup_and_space();
    write_limit(16'd0);
    text_bytes = '{CHAR_HASH, 8'h41, CHAR_SPACE, CHAR_TAB, CHAR_STAR, CHAR_LBRK, CHAR_RBRK,
                   CHAR_LPAR, CHAR_RPAR, CHAR_BANG, CHAR_GT, CHAR_UNDER, 8'h00, 8'hFF};
    send_text(1'b0);
  endtask

  task automatic test_code_fences();
    // two loose ticks outside code are dropped, then a fence with two held ticks
    text_bytes = '{CHAR_TICK, CHAR_TICK, 8'h71, CHAR_TICK, CHAR_TICK, CHAR_TICK, CHAR_TICK,
                   CHAR_TICK, 8'h63, CHAR_NL, CHAR_NL, CHAR_TAB};
    send_text(1'b0);
    send_item(mk(8'h55, 1'b0, 1'b0));
    text_bytes = '{CHAR_TICK, CHAR_TICK, CHAR_TICK, 8'h7A};
    send_text(1'b0);
    // held ticks in code mode flushed at the end
    text_bytes = '{CHAR_TICK, CHAR_TICK, CHAR_TICK, CHAR_TICK, CHAR_TICK};
    send_text(1'b1);
  endtask

  task automatic test_length_limit();
    write_limit(16'd1);
    // code bytes count without halting, the next plain byte halts
    text_bytes = '{CHAR_TICK, CHAR_TICK, CHAR_TICK, 8'h61, 8'h62, CHAR_TICK, CHAR_TICK,
                   CHAR_TICK, 8'h63, 8'h64};
    send_text(1'b0);
    text_bytes.delete();
    send_text(1'b1);
  endtask

  task automatic test_random_texts();
    in_item_t    rand_q[$];
    int          counted;
    int          n_len;
    int          r;
    logic [15:0] lim;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0: lim = 16'd0;
            1: lim = 16'd1;
            4: lim = 16'($urandom_range(13, 65535));
            default: lim = 16'($urandom_range(2, 12));
          endcase
          write_limit(lim);
        end
        rand_q.delete();
        n_len = $urandom_range(1, 16);
        for (int k = 0; k < n_len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            rand_q.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
          end else if (r < 40) begin
            rand_q.push_back(mk(8'($urandom_range(8'h30, 8'h7A)), 1'b1, 1'b0));
          end else if (r < 52) begin
            case ($urandom_range(0, 5))
              0: rand_q.push_back(mk(CHAR_SPACE, 1'b1, 1'b0));
              1: rand_q.push_back(mk(CHAR_TAB, 1'b1, 1'b0));
              2: rand_q.push_back(mk(CHAR_NL, 1'b1, 1'b0));
              3: rand_q.push_back(mk(8'h0B, 1'b1, 1'b0));
              4: rand_q.push_back(mk(8'h0C, 1'b1, 1'b0));
              default: rand_q.push_back(mk(CHAR_CR, 1'b1, 1'b0));
            endcase
          end else if (r < 64) begin
            case ($urandom_range(0, 8))
              0: rand_q.push_back(mk(CHAR_HASH, 1'b1, 1'b0));
              1: rand_q.push_back(mk(CHAR_STAR, 1'b1, 1'b0));
              2: rand_q.push_back(mk(CHAR_UNDER, 1'b1, 1'b0));
              3: rand_q.push_back(mk(CHAR_GT, 1'b1, 1'b0));
              4: rand_q.push_back(mk(CHAR_LBRK, 1'b1, 1'b0));
              5: rand_q.push_back(mk(CHAR_RBRK, 1'b1, 1'b0));
              6: rand_q.push_back(mk(CHAR_LPAR, 1'b1, 1'b0));
              7: rand_q.push_back(mk(CHAR_RPAR, 1'b1, 1'b0));
              default: rand_q.push_back(mk(CHAR_BANG, 1'b1, 1'b0));
            endcase
          end else if (r < 76) begin
            repeat (3) rand_q.push_back(mk(CHAR_TICK, 1'b1, 1'b0));
          end else if (r < 82) begin
            rand_q.push_back(mk(CHAR_TICK, 1'b1, 1'b0));
          end else if (r < 90) begin
            rand_q.push_back(mk(CHAR_NL, 1'b1, 1'b0));
          end else begin
            rand_q.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0));
          end
        end
        if ($urandom_range(0, 1)) rand_q.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b1));
        else rand_q.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        foreach (rand_q[i]) begin
          send_item(rand_q[i]);
          if (rand_q[i].byte_present || rand_q[i].end_of_text) counted++;
        end
        texts_sent++;
      end
    end
  endtask

  // receiver with random stalls and scoreboard check
  always @(posedge clk_i) begin : rx_check
    out_item_t exp_beat;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (expected_q.size() == 0) begin
          $error("unexpected beat: out_byte %02h out_present %0b out_last %0b",
                 out_item.out_byte, out_item.out_present, out_item.out_last);
          fail_count++;
        end else begin
          exp_beat = expected_q.pop_front();
          if (out_item.out_byte !== exp_beat.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", exp_beat.out_byte, out_item.out_byte);
            fail_count++;
          end
          if (out_item.out_present !== exp_beat.out_present) begin
            $error("out_present: expected %0b, actual %0b",
                   exp_beat.out_present, out_item.out_present);
            fail_count++;
          end
          if (out_item.out_last !== exp_beat.out_last) begin
            $error("out_last: expected %0b, actual %0b", exp_beat.out_last, out_item.out_last);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    clear_text();
    limit_val = 16'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_markup_and_space();
    test_code_fences();
    test_length_limit();
    test_random_texts();
    drain_and_settle();
    $display("%0d items in %0d texts sent, %0d output beats checked, %0d mismatches",
             items_sent, texts_sent, beats_checked, fail_count);
    $display("covered markup, whitespace, code fences, limits from 0 to 65535, three stall mixes");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
